// ===== rtl/assert_macros.svh =====
// Clocked assertion helpers; all are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ccta_pkg.sv =====
package ccta_pkg;

  localparam int unsigned DAYS_IN_MONTH  = 30;
  localparam int unsigned MONTHS_IN_YEAR = 12;
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned MIN_PER_HOUR   = 60;
  localparam int unsigned HOUR_PER_DAY   = 24;
  localparam int unsigned WEEK_LEN       = 7;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned SPT_W   = 6;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // constant divide: 17-bit dividend, divisors up to 60,
  // q = (x * ceil(2^24 / d)) >> 24 is exact for x < 2^17 and d < 128
  localparam int unsigned DIVD_W    = 17;
  localparam int unsigned REM_W     = 6;
  localparam int unsigned RCP_SHIFT = 24;
  localparam int unsigned RCP_W     = 22;
  localparam int unsigned PROD_W    = DIVD_W + RCP_W;
  localparam int unsigned QUO_W     = PROD_W - RCP_SHIFT;
  localparam int unsigned CARRY_W   = 13;
  localparam int unsigned HC_W      = 12;
  localparam int unsigned YSUM_W    = 18;

  localparam logic [RCP_W-1:0] RCP_SEC  =
    RCP_W'(((64'd1 << RCP_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN);
  localparam logic [RCP_W-1:0] RCP_MIN  =
    RCP_W'(((64'd1 << RCP_SHIFT) + MIN_PER_HOUR - 1) / MIN_PER_HOUR);
  localparam logic [RCP_W-1:0] RCP_HOUR =
    RCP_W'(((64'd1 << RCP_SHIFT) + HOUR_PER_DAY - 1) / HOUR_PER_DAY);
  localparam logic [RCP_W-1:0] RCP_DAY  =
    RCP_W'(((64'd1 << RCP_SHIFT) + DAYS_IN_MONTH - 1) / DAYS_IN_MONTH);
  localparam logic [RCP_W-1:0] RCP_MON  =
    RCP_W'(((64'd1 << RCP_SHIFT) + MONTHS_IN_YEAR - 1) / MONTHS_IN_YEAR);
  localparam logic [RCP_W-1:0] RCP_WDAY =
    RCP_W'(((64'd1 << RCP_SHIFT) + WEEK_LEN - 1) / WEEK_LEN);

  localparam int unsigned IN_DATA_W  = 6 * VAL_W;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SECONDS_PER_TICK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_PAUSED      = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_ADD       = 2'd1,
    CMD_SET       = 2'd2,
    CMD_RESET_DAY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_REM,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_SEC,
    PH_MIN,
    PH_HOUR,
    PH_DAY,
    PH_MON,
    PH_WDAY
  } phase_t;

  function automatic logic [REM_W-1:0] phase_divisor(input phase_t ph);
    logic [REM_W-1:0] d;
    case (ph)
      PH_SEC:  d = REM_W'(SEC_PER_MIN);
      PH_MIN:  d = REM_W'(MIN_PER_HOUR);
      PH_HOUR: d = REM_W'(HOUR_PER_DAY);
      PH_DAY:  d = REM_W'(DAYS_IN_MONTH);
      PH_MON:  d = REM_W'(MONTHS_IN_YEAR);
      default: d = REM_W'(WEEK_LEN);
    endcase
    return d;
  endfunction

  function automatic logic [RCP_W-1:0] phase_recip(input phase_t ph);
    logic [RCP_W-1:0] r;
    case (ph)
      PH_SEC:  r = RCP_SEC;
      PH_MIN:  r = RCP_MIN;
      PH_HOUR: r = RCP_HOUR;
      PH_DAY:  r = RCP_DAY;
      PH_MON:  r = RCP_MON;
      default: r = RCP_WDAY;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/calendar_clock_with_time_advance.sv =====
// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid/in_tready     tuser command, tdata six 16-bit values
// out_     out  out_tvalid/out_tready   tdata clock fields, tuser rejected
// cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Tick (unless paused) and add run six field steps on one shared divide unit
// by reciprocal multiply; each step passes through load, multiply and remainder.
// A valid set runs the weekday step only; reset-day, paused tick and rejected
// set go straight to the done state. Synchronous active-low reset; no
// clearing pass. One request at a time; a stalled result holds in the output
// register, the next request is taken meanwhile. cfg_ready is always high.
`include "assert_macros.svh"

module calendar_clock_with_time_advance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year_value, month_value, day_value, hour_value, minute_value,
  // second_value (16 bits each)
  input  logic [ccta_pkg::IN_DATA_W-1:0]      in_tdata,
  // command
  input  logic [ccta_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
  // cur_weekday, 3 zero bits
  output logic [ccta_pkg::OUT_DATA_W-1:0]     out_tdata,
  // rejected
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ccta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccta_pkg::SPT_W-1:0]          cfg_data
);

  localparam int unsigned VW = ccta_pkg::VAL_W;
  localparam int unsigned DW = ccta_pkg::DIVD_W;
  localparam int unsigned RW = ccta_pkg::REM_W;

  ccta_pkg::state_t state_r, state_nxt;
  ccta_pkg::phase_t phase_r, phase_nxt;

  logic [ccta_pkg::SPT_W-1:0]  spt_r, spt_nxt;
  logic                        paused_r, paused_nxt;

  logic [ccta_pkg::SEC_W-1:0]  sec_r, sec_nxt;
  logic [ccta_pkg::MIN_W-1:0]  min_r, min_nxt;
  logic [ccta_pkg::HOUR_W-1:0] hour_r, hour_nxt;
  logic [ccta_pkg::DAY_W-1:0]  day_r, day_nxt;
  logic [ccta_pkg::MON_W-1:0]  mon_r, mon_nxt;
  logic [ccta_pkg::YEAR_W-1:0] year_r, year_nxt;
  logic [ccta_pkg::WDAY_W-1:0] wday_r, wday_nxt;

  logic [VW-1:0] amt_y_r, amt_y_nxt;
  logic [VW-1:0] amt_mo_r, amt_mo_nxt;
  logic [VW-1:0] amt_d_r, amt_d_nxt;
  logic [VW-1:0] amt_h_r, amt_h_nxt;
  logic [VW-1:0] amt_mi_r, amt_mi_nxt;
  logic [VW-1:0] amt_s_r, amt_s_nxt;
  logic          adv_r, adv_nxt;
  logic          rej_r, rej_nxt;

  logic [ccta_pkg::CARRY_W-1:0] carry_r, carry_nxt;
  logic [ccta_pkg::HC_W-1:0]    hc_r, hc_nxt;

  logic [DW-1:0]                div_r, div_nxt;
  logic [ccta_pkg::QUO_W-1:0]   quo_r, quo_nxt;

  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [ccta_pkg::SEC_W-1:0]   o_sec_r, o_sec_nxt;
  logic [ccta_pkg::MIN_W-1:0]   o_min_r, o_min_nxt;
  logic [ccta_pkg::HOUR_W-1:0]  o_hour_r, o_hour_nxt;
  logic [ccta_pkg::DAY_W-1:0]   o_day_r, o_day_nxt;
  logic [ccta_pkg::MON_W-1:0]   o_mon_r, o_mon_nxt;
  logic [ccta_pkg::YEAR_W-1:0]  o_year_r, o_year_nxt;
  logic [ccta_pkg::WDAY_W-1:0]  o_wday_r, o_wday_nxt;
  logic                         o_rej_r, o_rej_nxt;

  logic [VW-1:0] yv, mv, dv, hv, nv, sv;
  ccta_pkg::cmd_t cmd;
  logic           in_acc;
  logic           set_ok;

  logic [RW-1:0]                dvsr;
  logic [ccta_pkg::RCP_W-1:0]   rcp;
  logic [ccta_pkg::PROD_W-1:0]  prod;
  logic [DW-1:0]                back;
  logic [DW-1:0]                rem_full;
  logic [RW-1:0]                rem;
  logic [DW-1:0]                dividend;
  logic [ccta_pkg::YSUM_W-1:0]  ysum;

  assign yv  = in_tdata[1*VW-1:0*VW];
  assign mv  = in_tdata[2*VW-1:1*VW];
  assign dv  = in_tdata[3*VW-1:2*VW];
  assign hv  = in_tdata[4*VW-1:3*VW];
  assign nv  = in_tdata[5*VW-1:4*VW];
  assign sv  = in_tdata[6*VW-1:5*VW];
  assign cmd = ccta_pkg::cmd_t'(in_tuser);

  assign in_tready = (state_r == ccta_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign set_ok = (mv >= VW'(1)) && (mv <= VW'(ccta_pkg::MONTHS_IN_YEAR)) &&
                  (dv >= VW'(1)) && (dv <= VW'(ccta_pkg::DAYS_IN_MONTH)) &&
                  (hv < VW'(ccta_pkg::HOUR_PER_DAY)) &&
                  (nv < VW'(ccta_pkg::MIN_PER_HOUR)) &&
                  (sv < VW'(ccta_pkg::SEC_PER_MIN));

  // shared divide: quotient by reciprocal multiply, remainder by multiply-back
  assign dvsr     = ccta_pkg::phase_divisor(phase_r);
  assign rcp      = ccta_pkg::phase_recip(phase_r);
  assign prod     = ccta_pkg::PROD_W'(div_r) * ccta_pkg::PROD_W'(rcp);
  assign back     = DW'(quo_r) * DW'(dvsr);
  assign rem_full = div_r - back;
  assign rem      = rem_full[RW-1:0];

  always_comb begin
    case (phase_r)
      ccta_pkg::PH_SEC:  dividend = DW'(sec_r) + DW'(amt_s_r) + DW'(carry_r);
      ccta_pkg::PH_MIN:  dividend = DW'(min_r) + DW'(amt_mi_r) + DW'(carry_r);
      ccta_pkg::PH_HOUR: dividend = DW'(hour_r) + DW'(amt_h_r) + DW'(carry_r);
      ccta_pkg::PH_DAY:  dividend = DW'(day_r) + DW'(amt_d_r) + DW'(carry_r) - DW'(1);
      ccta_pkg::PH_MON:  dividend = DW'(mon_r) + DW'(amt_mo_r) + DW'(carry_r) - DW'(1);
      default:           dividend = DW'(wday_r) + DW'(amt_d_r) + DW'(hc_r);
    endcase
  end

  assign ysum = ccta_pkg::YSUM_W'(year_r) + ccta_pkg::YSUM_W'(amt_y_r) +
                ccta_pkg::YSUM_W'(carry_r);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    spt_nxt        = spt_r;
    paused_nxt     = paused_r;
    sec_nxt        = sec_r;
    min_nxt        = min_r;
    hour_nxt       = hour_r;
    day_nxt        = day_r;
    mon_nxt        = mon_r;
    year_nxt       = year_r;
    wday_nxt       = wday_r;
    amt_y_nxt      = amt_y_r;
    amt_mo_nxt     = amt_mo_r;
    amt_d_nxt      = amt_d_r;
    amt_h_nxt      = amt_h_r;
    amt_mi_nxt     = amt_mi_r;
    amt_s_nxt      = amt_s_r;
    adv_nxt        = adv_r;
    rej_nxt        = rej_r;
    carry_nxt      = carry_r;
    hc_nxt         = hc_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    out_tvalid_nxt = out_tvalid_r;
    o_sec_nxt      = o_sec_r;
    o_min_nxt      = o_min_r;
    o_hour_nxt     = o_hour_r;
    o_day_nxt      = o_day_r;
    o_mon_nxt      = o_mon_r;
    o_year_nxt     = o_year_r;
    o_wday_nxt     = o_wday_r;
    o_rej_nxt      = o_rej_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        ccta_pkg::CFG_SECONDS_PER_TICK: spt_nxt = cfg_data;
        ccta_pkg::CFG_TIME_PAUSED:      paused_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ccta_pkg::ST_IDLE: begin
        if (in_acc) begin
          rej_nxt   = 1'b0;
          carry_nxt = '0;
          hc_nxt    = '0;
          phase_nxt = ccta_pkg::PH_SEC;
          adv_nxt   = 1'b1;
          unique case (cmd)
            ccta_pkg::CMD_TICK: begin
              amt_y_nxt  = '0;
              amt_mo_nxt = '0;
              amt_d_nxt  = '0;
              amt_h_nxt  = '0;
              amt_mi_nxt = '0;
              amt_s_nxt  = VW'(spt_r);
              state_nxt  = paused_r ? ccta_pkg::ST_DONE : ccta_pkg::ST_LOAD;
            end
            ccta_pkg::CMD_ADD: begin
              amt_y_nxt  = yv;
              amt_mo_nxt = mv;
              amt_d_nxt  = dv;
              amt_h_nxt  = hv;
              amt_mi_nxt = nv;
              amt_s_nxt  = sv;
              state_nxt  = ccta_pkg::ST_LOAD;
            end
            ccta_pkg::CMD_SET: begin
              if (set_ok) begin
                year_nxt  = yv;
                mon_nxt   = mv[ccta_pkg::MON_W-1:0];
                day_nxt   = dv[ccta_pkg::DAY_W-1:0];
                hour_nxt  = hv[ccta_pkg::HOUR_W-1:0];
                min_nxt   = nv[ccta_pkg::MIN_W-1:0];
                sec_nxt   = sv[ccta_pkg::SEC_W-1:0];
                // weekday = (day - 1) mod 7 through the divider
                wday_nxt  = '0;
                amt_d_nxt = dv - VW'(1);
                adv_nxt   = 1'b0;
                phase_nxt = ccta_pkg::PH_WDAY;
                state_nxt = ccta_pkg::ST_LOAD;
              end else begin
                rej_nxt   = 1'b1;
                state_nxt = ccta_pkg::ST_DONE;
              end
            end
            ccta_pkg::CMD_RESET_DAY: begin
              day_nxt   = ccta_pkg::DAY_W'(1);
              state_nxt = ccta_pkg::ST_DONE;
            end
            default: state_nxt = ccta_pkg::ST_DONE;
          endcase
        end
      end

      ccta_pkg::ST_LOAD: begin
        div_nxt = dividend;
        if (phase_r == ccta_pkg::PH_WDAY && adv_r) begin
          year_nxt = (ysum > ccta_pkg::YSUM_W'({ccta_pkg::YEAR_W{1'b1}})) ?
                     {ccta_pkg::YEAR_W{1'b1}} : ysum[ccta_pkg::YEAR_W-1:0];
        end
        state_nxt = ccta_pkg::ST_MUL;
      end

      ccta_pkg::ST_MUL: begin
        quo_nxt   = prod[ccta_pkg::PROD_W-1:ccta_pkg::RCP_SHIFT];
        state_nxt = ccta_pkg::ST_REM;
      end

      ccta_pkg::ST_REM: begin
        carry_nxt = quo_r[ccta_pkg::CARRY_W-1:0];
        state_nxt = ccta_pkg::ST_LOAD;
        case (phase_r)
          ccta_pkg::PH_SEC: begin
            sec_nxt   = rem[ccta_pkg::SEC_W-1:0];
            phase_nxt = ccta_pkg::PH_MIN;
          end
          ccta_pkg::PH_MIN: begin
            min_nxt   = rem[ccta_pkg::MIN_W-1:0];
            phase_nxt = ccta_pkg::PH_HOUR;
          end
          ccta_pkg::PH_HOUR: begin
            hour_nxt  = rem[ccta_pkg::HOUR_W-1:0];
            hc_nxt    = quo_r[ccta_pkg::HC_W-1:0];
            phase_nxt = ccta_pkg::PH_DAY;
          end
          ccta_pkg::PH_DAY: begin
            day_nxt   = rem[ccta_pkg::DAY_W-1:0] + ccta_pkg::DAY_W'(1);
            phase_nxt = ccta_pkg::PH_MON;
          end
          ccta_pkg::PH_MON: begin
            mon_nxt   = rem[ccta_pkg::MON_W-1:0] + ccta_pkg::MON_W'(1);
            phase_nxt = ccta_pkg::PH_WDAY;
          end
          default: begin
            wday_nxt  = rem[ccta_pkg::WDAY_W-1:0];
            state_nxt = ccta_pkg::ST_DONE;
          end
        endcase
      end

      ccta_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          o_sec_nxt      = sec_r;
          o_min_nxt      = min_r;
          o_hour_nxt     = hour_r;
          o_day_nxt      = day_r;
          o_mon_nxt      = mon_r;
          o_year_nxt     = year_r;
          o_wday_nxt     = wday_r;
          o_rej_nxt      = rej_r;
          state_nxt      = ccta_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ccta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccta_pkg::ST_IDLE;
      phase_r      <= ccta_pkg::PH_SEC;
      spt_r        <= ccta_pkg::SPT_W'(1);
      paused_r     <= 1'b0;
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
      day_r        <= ccta_pkg::DAY_W'(1);
      mon_r        <= ccta_pkg::MON_W'(1);
      year_r       <= '0;
      wday_r       <= '0;
      adv_r        <= 1'b0;
      rej_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      spt_r        <= spt_nxt;
      paused_r     <= paused_nxt;
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
      day_r        <= day_nxt;
      mon_r        <= mon_nxt;
      year_r       <= year_nxt;
      wday_r       <= wday_nxt;
      adv_r        <= adv_nxt;
      rej_r        <= rej_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_y_r  <= amt_y_nxt;
    amt_mo_r <= amt_mo_nxt;
    amt_d_r  <= amt_d_nxt;
    amt_h_r  <= amt_h_nxt;
    amt_mi_r <= amt_mi_nxt;
    amt_s_r  <= amt_s_nxt;
    carry_r  <= carry_nxt;
    hc_r     <= hc_nxt;
    div_r    <= div_nxt;
    quo_r    <= quo_nxt;
    o_sec_r  <= o_sec_nxt;
    o_min_r  <= o_min_nxt;
    o_hour_r <= o_hour_nxt;
    o_day_r  <= o_day_nxt;
    o_mon_r  <= o_mon_nxt;
    o_year_r <= o_year_nxt;
    o_wday_r <= o_wday_nxt;
    o_rej_r  <= o_rej_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = o_rej_r;
  assign out_tdata  = {3'b000, o_wday_r, o_year_r, o_mon_r, o_day_r,
                       o_hour_r, o_min_r, o_sec_r};

  `ASSERT_CLK(a_fields_in_range,
    (sec_r < ccta_pkg::SEC_W'(ccta_pkg::SEC_PER_MIN)) &&
    (min_r < ccta_pkg::MIN_W'(ccta_pkg::MIN_PER_HOUR)) &&
    (hour_r < ccta_pkg::HOUR_W'(ccta_pkg::HOUR_PER_DAY)) &&
    (day_r != '0) && (day_r <= ccta_pkg::DAY_W'(ccta_pkg::DAYS_IN_MONTH)) &&
    (mon_r != '0) && (mon_r <= ccta_pkg::MON_W'(ccta_pkg::MONTHS_IN_YEAR)) &&
    (wday_r < ccta_pkg::WDAY_W'(ccta_pkg::WEEK_LEN)),
    "clock field out of range")
  `ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready,
    "ready held high after an accepted request")
  `ASSERT_NEXT(a_paused_tick_holds, in_acc && (cmd == ccta_pkg::CMD_TICK) && paused_r,
    $stable(sec_r) && $stable(min_r) && $stable(hour_r) && $stable(day_r) &&
    $stable(year_r),
    "paused tick changed the clock")
  `ASSERT_NEXT(a_mul_then_rem, state_r == ccta_pkg::ST_MUL,
    state_r == ccta_pkg::ST_REM, "multiply step not followed by remainder step")

endmodule
